@@ rtl/core/lcs_pkg.sv @@
`default_nettype none

package lcs_pkg;

  localparam int unsigned NUM_BACKENDS = 8;
  localparam int unsigned COUNT_WIDTH  = 16;

  localparam int unsigned IDX_W = $clog2(NUM_BACKENDS);
  localparam int unsigned NUM_W = $clog2(NUM_BACKENDS + 1);
  localparam int unsigned BC_W  = (NUM_W > 4) ? NUM_W : 4;

  localparam int unsigned CMD_W     = 1;
  localparam int unsigned REL_W     = 3;
  localparam int unsigned OIDX_W    = 3;
  localparam int unsigned OCNT_W    = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned APB_AW    = 2;
  localparam int unsigned APB_DW    = 32;

  localparam logic [APB_AW-1:0] ADDR_BACKEND_COUNT = 2'd0;
  localparam logic [3:0]        BACKEND_COUNT_RST  = 4'd8;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED  = 2'd0,
    ST_RELEASED  = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0]       idx_t;

endpackage

`default_nettype wire

@@ rtl/core/lcs_if.sv @@
`default_nettype none

interface lcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [lcs_pkg::CMD_W-1:0]     cmd;
  logic [lcs_pkg::REL_W-1:0]     release_index;

  modport source (output valid, output cmd, output release_index, input ready);
  modport sink   (input valid, input cmd, input release_index, output ready);
endinterface

interface lcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcs_pkg::OIDX_W-1:0]    backend_index;
  logic [lcs_pkg::OCNT_W-1:0]    connection_count;
  logic [lcs_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output backend_index, output connection_count,
                  output status, input ready);
  modport sink   (input valid, input backend_index, input connection_count,
                  input status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/least_connections_selector.sv @@
`default_nettype none

// Channel   Dir  Role    Payload
// in_i      in   sink    cmd, release_index
// out_o     out  source  backend_index, connection_count, status
// apb       in   slave   backend_count at byte address 0
//
// Acquire: scans the n backends in use, one counter read per cycle from the
// counter memory (one read, one write port). Release reads one counter. One
// item in flight; the result waits in an output register and the next
// transfer is taken once it has been written back.
// Reset clears the per-entry valid bits, so all counters read as zero.

module least_connections_selector (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  lcs_in_if.sink                            in_i,
  lcs_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lcs_pkg::APB_AW-1:0]   paddr,
  input  wire logic [lcs_pkg::APB_DW-1:0]   pwdata,
  output logic      [lcs_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WB
  } state_e;

  state_e state_q;

  logic [3:0] bc_q;

  // counter memory
  lcs_pkg::count_t mem [lcs_pkg::NUM_BACKENDS];
  logic [lcs_pkg::NUM_BACKENDS-1:0] vld_q;
  lcs_pkg::count_t rdata_q;
  logic            rvld_q;

  lcs_pkg::idx_t   i_q;
  lcs_pkg::idx_t   last_q;
  lcs_pkg::idx_t   pidx_q;
  logic            pend_q;
  lcs_pkg::cmd_e   cmd_q;
  logic [lcs_pkg::REL_W-1:0] rel_q;
  logic            rel_use_q;
  logic            rel_mem_q;
  lcs_pkg::count_t best_q;
  lcs_pkg::idx_t   bidx_q;

  logic            wb_en_q;
  lcs_pkg::idx_t   wb_addr_q;
  lcs_pkg::count_t wb_data_q;
  logic [lcs_pkg::OIDX_W-1:0]   res_idx_q;
  logic [lcs_pkg::OCNT_W-1:0]   res_cnt_q;
  lcs_pkg::status_e             res_st_q;

  logic                         out_valid_q;
  logic [lcs_pkg::OIDX_W-1:0]   out_idx_q;
  logic [lcs_pkg::OCNT_W-1:0]   out_cnt_q;
  lcs_pkg::status_e             out_st_q;

  // APB
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && (paddr == lcs_pkg::ADDR_BACKEND_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr == lcs_pkg::ADDR_BACKEND_COUNT) ?
                  {{(lcs_pkg::APB_DW-4){1'b0}}, bc_q} : '0;

  // effective backend count and release range checks
  logic [lcs_pkg::BC_W-1:0] bc_ext, n_eff, last_ext, rel_ext;
  always_comb begin
    bc_ext = lcs_pkg::BC_W'(bc_q);
    n_eff  = bc_ext;
    if (bc_ext == '0) begin
      n_eff = lcs_pkg::BC_W'(1);
    end
    if (bc_ext > lcs_pkg::BC_W'(lcs_pkg::NUM_BACKENDS)) begin
      n_eff = lcs_pkg::BC_W'(lcs_pkg::NUM_BACKENDS);
    end
    last_ext = n_eff - lcs_pkg::BC_W'(1);
    rel_ext  = lcs_pkg::BC_W'(in_i.release_index);
  end

  // scan compare on the entry read last cycle
  lcs_pkg::count_t cur, fin_cnt;
  lcs_pkg::idx_t   fin_idx;
  logic            take;
  always_comb begin
    cur     = rvld_q ? rdata_q : '0;
    take    = (pidx_q == '0) || (cur < best_q);
    fin_cnt = take ? cur : best_q;
    fin_idx = take ? pidx_q : bidx_q;
  end

  // result of the operation, evaluated in S_DRAIN
  logic                         r_we;
  lcs_pkg::count_t              r_data;
  lcs_pkg::idx_t                r_addr;
  lcs_pkg::count_t              r_cnt;
  logic [lcs_pkg::OIDX_W-1:0]   r_idx;
  lcs_pkg::status_e             r_st;
  logic [lcs_pkg::IDX_W+lcs_pkg::OIDX_W-1:0]      idx_ext;
  logic [lcs_pkg::COUNT_WIDTH+lcs_pkg::OCNT_W-1:0] cnt_ext;
  always_comb begin
    r_we    = 1'b0;
    r_data  = cur;
    r_addr  = pidx_q;
    r_cnt   = cur;
    r_st    = lcs_pkg::ST_IGNORED;
    idx_ext = {{lcs_pkg::OIDX_W{1'b0}}, fin_idx};
    r_idx   = rel_q;
    if (cmd_q == lcs_pkg::CMD_ACQUIRE) begin
      r_addr = fin_idx;
      r_idx  = idx_ext[lcs_pkg::OIDX_W-1:0];
      if (fin_cnt == lcs_pkg::CNT_MAX) begin
        r_cnt = fin_cnt;
        r_st  = lcs_pkg::ST_SATURATED;
      end else begin
        r_we   = 1'b1;
        r_data = fin_cnt + lcs_pkg::count_t'(1);
        r_cnt  = r_data;
        r_st   = lcs_pkg::ST_ACQUIRED;
      end
    end else begin
      if (rel_use_q && (cur != '0)) begin
        r_we   = 1'b1;
        r_data = cur - lcs_pkg::count_t'(1);
        r_cnt  = r_data;
        r_st   = lcs_pkg::ST_RELEASED;
      end else begin
        r_cnt = rel_mem_q ? cur : '0;
      end
    end
    cnt_ext = {{lcs_pkg::OCNT_W{1'b0}}, r_cnt};
  end

  logic wb_go;
  assign wb_go = (state_q == S_WB) && (!out_valid_q || out_o.ready);

  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.backend_index    = out_idx_q;
  assign out_o.connection_count = out_cnt_q;
  assign out_o.status           = out_st_q;

  // memory
  always_ff @(posedge clk_i) begin
    if (wb_go && wb_en_q) begin
      mem[wb_addr_q] <= wb_data_q;
    end
    rdata_q <= mem[i_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wb_go && wb_en_q) begin
        vld_q[wb_addr_q] <= 1'b1;
      end
      rvld_q <= vld_q[i_q];
    end
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= lcs_pkg::BACKEND_COUNT_RST;
    end else if (cfg_we) begin
      bc_q <= pwdata[3:0];
    end
  end

  // control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      i_q         <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !wb_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q     <= lcs_pkg::cmd_e'(in_i.cmd);
            rel_q     <= in_i.release_index;
            last_q    <= last_ext[lcs_pkg::IDX_W-1:0];
            rel_use_q <= (rel_ext <= last_ext);
            rel_mem_q <= (rel_ext < lcs_pkg::BC_W'(lcs_pkg::NUM_BACKENDS));
            pend_q    <= 1'b0;
            if (lcs_pkg::cmd_e'(in_i.cmd) == lcs_pkg::CMD_ACQUIRE) begin
              i_q <= '0;
            end else begin
              i_q <= rel_ext[lcs_pkg::IDX_W-1:0];
            end
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_q <= 1'b1;
          pidx_q <= i_q;
          if (pend_q) begin
            best_q <= fin_cnt;
            bidx_q <= fin_idx;
          end
          if ((cmd_q == lcs_pkg::CMD_RELEASE) || (i_q == last_q)) begin
            state_q <= S_DRAIN;
          end else begin
            i_q <= i_q + lcs_pkg::idx_t'(1);
          end
        end
        S_DRAIN: begin
          pend_q    <= 1'b0;
          wb_en_q   <= r_we;
          wb_addr_q <= r_addr;
          wb_data_q <= r_data;
          res_idx_q <= r_idx;
          res_cnt_q <= cnt_ext[lcs_pkg::OCNT_W-1:0];
          res_st_q  <= r_st;
          state_q   <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= res_idx_q;
            out_cnt_q   <= res_cnt_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ verif/least_connections_selector_test.sv @@
module least_connections_selector_test;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS = 84;

  typedef struct {
    logic [lcs_pkg::OIDX_W-1:0] backend_index;
    lcs_pkg::count_t            connection_count;
    lcs_pkg::status_e           status;
  } sel_result_t;

  logic clk;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lcs_pkg::APB_AW-1:0] paddr;
  logic [lcs_pkg::APB_DW-1:0] pwdata;
  logic [lcs_pkg::APB_DW-1:0] prdata;
  logic pready;

  lcs_in_if  req_ch ();
  lcs_out_if sel_ch ();

  least_connections_selector dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (req_ch),
    .out_o   (sel_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lcs_pkg::count_t conn_counts [lcs_pkg::NUM_BACKENDS];
  logic [3:0]  backend_count_q;
  sel_result_t pending_results [$];
  sel_result_t head_result;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned max_gap;
  int unsigned max_stall;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned active_count();
    int unsigned n;
    n = backend_count_q;
    if (n == 0) n = 1;
    if (n > lcs_pkg::NUM_BACKENDS) n = lcs_pkg::NUM_BACKENDS;
    return n;
  endfunction

  function automatic sel_result_t predict_selection(lcs_pkg::cmd_e cmd,
                                                    logic [lcs_pkg::REL_W-1:0] rel);
    sel_result_t r;
    int unsigned n;
    int unsigned idx;
    n = active_count();
    if (cmd == lcs_pkg::CMD_ACQUIRE) begin
      idx = 0;
      for (int unsigned i = 1; i < n; i++) begin
        if (conn_counts[i] < conn_counts[idx]) idx = i;
      end
      if (conn_counts[idx] == lcs_pkg::CNT_MAX) begin
        r.status = lcs_pkg::ST_SATURATED;
      end else begin
        conn_counts[idx] = conn_counts[idx] + lcs_pkg::count_t'(1);
        r.status = lcs_pkg::ST_ACQUIRED;
      end
    end else begin
      idx = rel;
      if (idx < n && conn_counts[idx] != '0) begin
        conn_counts[idx] = conn_counts[idx] - lcs_pkg::count_t'(1);
        r.status = lcs_pkg::ST_RELEASED;
      end else begin
        r.status = lcs_pkg::ST_IGNORED;
      end
    end
    r.backend_index = idx[lcs_pkg::OIDX_W-1:0];
    r.connection_count = conn_counts[idx];
    return r;
  endfunction

  function automatic logic [lcs_pkg::REL_W-1:0] pick_release_index();
    int unsigned busy [$];
    for (int unsigned i = 0; i < active_count(); i++) begin
      if (conn_counts[i] != '0) busy.push_back(i);
    end
    if (busy.size() != 0 && $urandom_range(0, 99) < 75)
      return lcs_pkg::REL_W'(busy[$urandom_range(0, busy.size() - 1)]);
    return lcs_pkg::REL_W'($urandom_range(0, lcs_pkg::NUM_BACKENDS - 1));
  endfunction

  task automatic send_request(input lcs_pkg::cmd_e cmd,
                              input logic [lcs_pkg::REL_W-1:0] rel);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.release_index <= rel;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_selection(cmd, rel));
  endtask

  task automatic drain_requests();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [lcs_pkg::APB_DW-1:0] wdata,
                              output logic [lcs_pkg::APB_DW-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= lcs_pkg::ADDR_BACKEND_COUNT;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) backend_count_q = wdata[3:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_backend_count(input logic [3:0] value);
    logic [lcs_pkg::APB_DW-1:0] rdata;
    drain_requests();
    apb_transfer(1'b1, lcs_pkg::APB_DW'(value), rdata);
    apb_transfer(1'b0, '0, rdata);
    if (rdata[3:0] !== backend_count_q) begin
      $display("%0t: backend_count expected %0d actual %0d", $time, backend_count_q,
               rdata[3:0]);
      mismatch_count++;
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (sel_ch.valid && sel_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %0d/%0d/%0d", $time,
                 sel_ch.backend_index, sel_ch.connection_count, sel_ch.status);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("backend_index", head_result.backend_index, sel_ch.backend_index);
        check_field("connection_count", head_result.connection_count,
                    sel_ch.connection_count);
        check_field("status", head_result.status, sel_ch.status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    sel_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, max_stall);
      if (stall > 0) begin
        sel_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      sel_ch.ready <= 1'b1;
      do @(posedge clk); while (!(sel_ch.valid && sel_ch.ready));
    end
  end

  task automatic test_directed();
    max_gap = 12;
    max_stall = 12;
    send_request(lcs_pkg::CMD_RELEASE, 3'd0);
    send_request(lcs_pkg::CMD_RELEASE, 3'd7);
    repeat (9) send_request(lcs_pkg::CMD_ACQUIRE, 3'd7);
    send_request(lcs_pkg::CMD_RELEASE, 3'd7);
    send_request(lcs_pkg::CMD_RELEASE, 3'd0);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd0);
    cfg_backend_count(4'd3);
    send_request(lcs_pkg::CMD_RELEASE, 3'd5);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd5);
    send_request(lcs_pkg::CMD_RELEASE, 3'd2);
    cfg_backend_count(4'd0);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd0);
    send_request(lcs_pkg::CMD_RELEASE, 3'd1);
    send_request(lcs_pkg::CMD_RELEASE, 3'd0);
    cfg_backend_count(4'd15);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd0);
    send_request(lcs_pkg::CMD_RELEASE, 3'd7);
    cfg_backend_count(4'd1);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd0);
    send_request(lcs_pkg::CMD_RELEASE, 3'd4);
  endtask

  task automatic test_random();
    logic [3:0] phase_count [5];
    int unsigned phase_gap [5];
    int unsigned phase_stall [5];
    phase_count = '{4'd8, 4'd1, 4'($urandom_range(0, 15)), 4'd15, 4'($urandom_range(2, 7))};
    phase_gap = '{12, 0, 12, 0, 12};
    phase_stall = '{12, 0, 0, 12, 12};
    for (int p = 0; p < 5; p++) begin
      cfg_backend_count(phase_count[p]);
      max_gap = phase_gap[p];
      max_stall = phase_stall[p];
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain_requests();
        if ($urandom_range(0, 99) < 52) send_request(lcs_pkg::CMD_ACQUIRE, 3'($urandom()));
        else send_request(lcs_pkg::CMD_RELEASE, pick_release_index());
      end
    end
  endtask

  task automatic test_single_backend();
    cfg_backend_count(4'd1);
    max_gap = 12;
    max_stall = 12;
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd0);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd6);
    send_request(lcs_pkg::CMD_RELEASE, 3'd0);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd0);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd0);
    cfg_backend_count(4'd2);
    send_request(lcs_pkg::CMD_ACQUIRE, 3'd0);
    send_request(lcs_pkg::CMD_RELEASE, 3'd0);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = lcs_pkg::CMD_ACQUIRE;
    req_ch.release_index = '0;
    mismatch_count = 0;
    cycle_count = 0;
    max_gap = 0;
    max_stall = 0;
    backend_count_q = lcs_pkg::BACKEND_COUNT_RST;
    for (int i = 0; i < lcs_pkg::NUM_BACKENDS; i++) conn_counts[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_directed();
    test_random();
    test_single_backend();

    drain_requests();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ least_connections_selector.f @@
rtl/core/lcs_pkg.sv
rtl/core/lcs_if.sv
rtl/core/least_connections_selector.sv
verif/least_connections_selector_test.sv
